[rtl/tsc_pkg.sv]
// Shared types and constants for the Taylor series sine/cosine block.
// Depends on nothing; every other file imports it.
package tsc_pkg;

  // Series length limit and counter widths
  localparam int MAX_TERMS = 16;
  localparam int CNT_W     = $clog2(MAX_TERMS + 1);
  localparam int D_W       = $clog2(4 * MAX_TERMS * MAX_TERMS + 1);

  // Field widths on the channels
  localparam int ANG_W    = 26;
  localparam int TCNT_W   = 5;
  localparam int RESULT_W = 32;

  // Internal fixed-point widths (Q32 magnitudes)
  localparam int X_W    = 36;
  localparam int TERM_W = 62;
  localparam int NUM_W  = 64;

  // Degrees to radians: x = angle * 314159 / 18000000, rounded
  localparam int RAD_NUM  = 314159;
  localparam int RAD_DEN  = 18000000;
  localparam int RAD_BIAS = RAD_DEN / 2;
  localparam int DIV_W    = $clog2(RAD_DEN + 1);

  // Divider: quotient bits retired per cycle and cycles per division
  localparam int DIV_STEP = 4;
  localparam int DIV_CYC  = NUM_W / DIV_STEP;
  localparam int DCNT_W   = $clog2(DIV_CYC + 1);

  localparam logic [63:0]        TERM_LIM = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SUM_LIM  = 64'sh4000_0000_0000_0000;
  localparam logic [63:0]        ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0]        HH_LIM   = 64'h0000_0000_4000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANG_MUL,
    ST_ANG_START,
    ST_ANG_DIV,
    ST_MQ_HH,
    ST_MQ_HL,
    ST_MQ_LH,
    ST_MQ_LL,
    ST_MQ_FIN,
    ST_X2,
    ST_SER_INIT,
    ST_TERM_START,
    ST_TERM_DIV,
    ST_SER_END
  } tsc_state_t;

  typedef enum logic [1:0] {
    PH_SQ,
    PH_SIN,
    PH_COS
  } phase_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_ANGLE,
    MUL_HH,
    MUL_HL,
    MUL_LH,
    MUL_LL
  } mul_op_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_HH,
    ACC_FULL,
    ACC_ROUND
  } acc_op_t;

  typedef enum logic [1:0] {
    DIV_NONE,
    DIV_ANGLE,
    DIV_TERM
  } div_op_t;

  typedef enum logic [2:0] {
    TAKE_NONE,
    TAKE_X,
    TAKE_X2,
    TAKE_INIT_SIN,
    TAKE_INIT_COS,
    TAKE_TERM,
    TAKE_SINE,
    TAKE_OUT
  } take_t;

  typedef struct packed {
    logic             load_in;
    mul_op_t          mul_op;
    acc_op_t          acc_op;
    logic             sq;
    div_op_t          div_op;
    logic             load_d;
    logic             odd;
    logic [CNT_W-1:0] term_idx;
    take_t            take;
  } tsc_cmd_t;

  typedef struct packed {
    logic div_busy;
  } tsc_stat_t;

endpackage

[rtl/tsc_ifs.sv]
// Valid/ready channel interfaces for the angle input and the result output.
// Depends on tsc_pkg for the field widths.
interface tsc_angle_if import tsc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] angle_deg;
  logic [TCNT_W-1:0]       term_count;

  modport source (output valid, angle_deg, term_count, input ready);
  modport sink   (input valid, angle_deg, term_count, output ready);
endinterface

interface tsc_result_if import tsc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] sine_value;
  logic signed [RESULT_W-1:0] cosine_value;
  logic                       saturated;

  modport source (output valid, sine_value, cosine_value, saturated, input ready);
  modport sink   (input valid, sine_value, cosine_value, saturated, output ready);
endinterface

[rtl/taylor_sine_cosine.sv]
// Truncated Taylor series sine and cosine of an angle in degrees.
// Usage:
//   angle  (sink)   : one beat carries angle_deg (signed, 16 fraction bits) and
//                     term_count (0 is taken as 1, above MAX_TERMS clamps).
//   result (source) : one beat per angle beat with sine_value and cosine_value
//                     (signed, 24 fraction bits) and a saturated flag.
// The shared multiplier and the divider do the work: each term takes four 32x32
// partial products and one 64-bit division by the term's constant, retired four
// quotient bits per cycle, and the two series run one after the other.
// The angle channel is ready only in the idle state, so one item is in flight
// at a time; the next one can be taken in the cycle after a result is loaded.
// A finished result sits in its own output register, so the next angle beat is
// accepted and worked on while the receiver stalls; the work waits at its end
// only if the earlier result has still not been taken.
// Reset (rst, synchronous, active high) returns the controller to idle, drops
// result valid and holds angle ready low; there is no clearing pass.
// Depends on tsc_pkg, tsc_ifs, tsc_ctrl, tsc_datapath and tsc_divider.
module taylor_sine_cosine import tsc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  tsc_angle_if.sink    angle,
  tsc_result_if.source result
);

  tsc_cmd_t  cmd;
  tsc_stat_t stat;

  // Sequencing: handshakes, term counting and command issue
  tsc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (angle.valid),
    .in_ready   (angle.ready),
    .term_count (angle.term_count),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Arithmetic: multiplier, divider, accumulators and the output register
  tsc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .angle_deg    (angle.angle_deg),
    .sine_value   (result.sine_value),
    .cosine_value (result.cosine_value),
    .saturated    (result.saturated)
  );

endmodule

[rtl/tsc_divider.sv]
// Multi-cycle restoring divider, DIV_STEP quotient bits per cycle.
// Depends on tsc_pkg for widths and step count.
module tsc_divider import tsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DIV_W-1:0] dsr,
  output logic             busy,
  output logic [NUM_W-1:0] quot
);

  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  rem_next;
  logic [DIV_W-1:0]  dsr_r;
  logic [NUM_W-1:0]  numq;
  logic [NUM_W-1:0]  numq_next;
  logic [DIV_W:0]    trial;

  // Shift numerator bits into the remainder; quotient bits fill from the bottom
  always_comb begin
    rem_next  = rem;
    numq_next = numq;
    trial     = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial     = {rem_next, numq_next[NUM_W-1]};
      numq_next = {numq_next[NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        trial        = trial - {1'b0, dsr_r};
        numq_next[0] = 1'b1;
      end
      rem_next = trial[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DCNT_W'(DIV_CYC);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      numq  <= num;
      rem   <= '0;
      dsr_r <= dsr;
    end else if (cnt != '0) begin
      numq <= numq_next;
      rem  <= rem_next;
    end
  end

  assign busy = (cnt != '0);
  assign quot = numq;

endmodule

[rtl/tsc_datapath.sv]
// Datapath: shared 32x32 multiplier, Q32 product assembly with clipping,
// series accumulators and output rounding. Depends on tsc_pkg, tsc_divider.
module tsc_datapath import tsc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  tsc_cmd_t                   cmd,
  output tsc_stat_t                  stat,
  input  logic signed [ANG_W-1:0]    angle_deg,
  output logic signed [RESULT_W-1:0] sine_value,
  output logic signed [RESULT_W-1:0] cosine_value,
  output logic                       saturated
);

  logic [ANG_W-1:0]        amag;
  logic                    ang_neg;
  logic [X_W-1:0]          xval;
  logic [TERM_W-1:0]       x2;
  logic [TERM_W-1:0]       mag;
  logic                    neg;
  logic signed [63:0]      sum;
  logic [TERM_W-1:0]       r;
  logic [63:0]             prod;
  logic [D_W-1:0]          d;
  logic                    sat;
  logic [RESULT_W-1:0]     sine_q;

  logic [31:0]             ma;
  logic [31:0]             mb;
  logic [63:0]             opa;
  logic [63:0]             opb;
  logic [CNT_W:0]          tw;
  logic [D_W-1:0]          d_next;

  logic [63:0]             m_full;
  logic                    mf_sat;
  logic [32:0]             m_rnd;
  logic [63:0]             s_acc;
  logic [TERM_W-1:0]       r_next;
  logic                    acc_sat;

  logic [TERM_W-1:0]       q_mag;
  logic signed [63:0]      s_term;
  logic signed [63:0]      sum_term;
  logic                    term_sat;

  logic                    div_start;
  logic [NUM_W-1:0]        div_num;
  logic [DIV_W-1:0]        div_dsr;
  logic                    div_busy;
  logic [NUM_W-1:0]        quot;

  logic [32:0]             q24;

  function automatic logic [32:0] to_q24(input logic signed [63:0] s);
    logic [63:0] m;
    logic [55:0] rr;
    logic [31:0] v;
    logic        f;
    m  = s[63] ? (64'd0 - $unsigned(s)) : $unsigned(s);
    rr = 56'((m + 64'd128) >> 8);
    f  = 1'b0;
    if (s[63]) begin
      if (rr > 56'h0000_0080_0000_00) begin
        rr = 56'h0000_0080_0000_00;
        f  = 1'b1;
      end
      v = 32'(56'd0 - rr);
    end else begin
      if (rr > 56'h0000_007F_FFFF_FF) begin
        rr = 56'h0000_007F_FFFF_FF;
        f  = 1'b1;
      end
      v = rr[31:0];
    end
    return {f, v};
  endfunction

  // Multiplier operand selection
  assign opa = cmd.sq ? 64'(xval) : 64'(mag);
  assign opb = cmd.sq ? 64'(xval) : 64'(x2);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.mul_op)
      MUL_ANGLE: begin
        ma = 32'(amag);
        mb = 32'(RAD_NUM);
      end
      MUL_HH: begin
        ma = opa[63:32];
        mb = opb[63:32];
      end
      MUL_HL: begin
        ma = opa[63:32];
        mb = opb[31:0];
      end
      MUL_LH: begin
        ma = opa[31:0];
        mb = opb[63:32];
      end
      MUL_LL: begin
        ma = opa[31:0];
        mb = opb[31:0];
      end
      default: ;
    endcase
  end

  // Divisor of the current term: (2i)(2i+1) for sine, (2i-1)(2i) for cosine
  assign tw     = {cmd.term_idx, 1'b0};
  assign d_next = cmd.odd ? D_W'(D_W'(tw) * D_W'(tw + 1'b1))
                          : D_W'(D_W'(tw - 1'b1) * D_W'(tw));

  // Assemble the Q32 product one partial product at a time, holding at the limit
  always_comb begin
    m_full = prod;
    mf_sat = 1'b0;
    if (prod > TERM_LIM) begin
      m_full = TERM_LIM;
      mf_sat = 1'b1;
    end
    m_rnd   = 33'((65'(prod) + 65'h0_8000_0000) >> 32);
    s_acc   = '0;
    r_next  = r;
    acc_sat = 1'b0;
    case (cmd.acc_op)
      ACC_HH: begin
        if (prod >= HH_LIM) begin
          r_next  = TERM_LIM[TERM_W-1:0];
          acc_sat = 1'b1;
        end else begin
          r_next = {prod[TERM_W-33:0], 32'd0};
        end
      end
      ACC_FULL: begin
        s_acc   = {2'b00, r} + m_full;
        acc_sat = mf_sat;
        if (s_acc > TERM_LIM) begin
          r_next  = TERM_LIM[TERM_W-1:0];
          acc_sat = 1'b1;
        end else begin
          r_next = s_acc[TERM_W-1:0];
        end
      end
      ACC_ROUND: begin
        s_acc = {2'b00, r} + 64'(m_rnd);
        if (s_acc > TERM_LIM) begin
          r_next  = TERM_LIM[TERM_W-1:0];
          acc_sat = 1'b1;
        end else begin
          r_next = s_acc[TERM_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // Add the new term with alternating sign, clamp the running sum
  always_comb begin
    q_mag    = quot[TERM_W-1:0];
    s_term   = neg ? $signed({2'b00, q_mag}) : -$signed({2'b00, q_mag});
    sum_term = sum + s_term;
    term_sat = 1'b0;
    if (sum_term > SUM_LIM) begin
      sum_term = SUM_LIM;
      term_sat = 1'b1;
    end else if (sum_term < -SUM_LIM) begin
      sum_term = -SUM_LIM;
      term_sat = 1'b1;
    end
  end

  assign q24 = to_q24(sum);

  // Divider launch
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_dsr   = '0;
    case (cmd.div_op)
      DIV_ANGLE: begin
        div_start = 1'b1;
        div_num   = (prod << 16) + 64'(RAD_BIAS);
        div_dsr   = DIV_W'(RAD_DEN);
      end
      DIV_TERM: begin
        div_start = 1'b1;
        div_num   = {2'b00, r} + 64'(d >> 1);
        div_dsr   = DIV_W'(d);
      end
      default: ;
    endcase
  end

  tsc_divider u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .dsr   (div_dsr),
    .busy  (div_busy),
    .quot  (quot)
  );

  assign stat.div_busy = div_busy;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      ang_neg <= angle_deg[ANG_W-1];
      amag    <= angle_deg[ANG_W-1] ? (~angle_deg + 1'b1) : angle_deg;
    end
    if (cmd.mul_op != MUL_NONE) begin
      prod <= 64'(ma) * 64'(mb);
    end
    if (cmd.acc_op != ACC_NONE) begin
      r <= r_next;
    end
    if (cmd.load_d) begin
      d <= d_next;
    end
    case (cmd.take)
      TAKE_X: xval <= quot[X_W-1:0];
      TAKE_X2: x2 <= r;
      TAKE_INIT_SIN: begin
        mag <= TERM_W'(xval);
        neg <= ang_neg;
        sum <= ang_neg ? -$signed(64'(xval)) : $signed(64'(xval));
      end
      TAKE_INIT_COS: begin
        mag <= ONE_Q32[TERM_W-1:0];
        neg <= 1'b0;
        sum <= $signed(ONE_Q32);
      end
      TAKE_TERM: begin
        mag <= q_mag;
        neg <= ~neg;
        sum <= sum_term;
      end
      TAKE_SINE: sine_q <= q24[RESULT_W-1:0];
      TAKE_OUT: begin
        sine_value   <= sine_q;
        cosine_value <= q24[RESULT_W-1:0];
        saturated    <= sat | q24[32];
      end
      default: ;
    endcase
  end

  // Saturation seen anywhere in the current item
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sat <= 1'b0;
    end else begin
      sat <= sat | acc_sat
                 | ((cmd.take == TAKE_TERM) & term_sat)
                 | ((cmd.take == TAKE_SINE) & q24[32]);
    end
  end

endmodule

[rtl/tsc_ctrl.sv]
// Controller: sequences the angle conversion, the squaring and both series.
// Depends on tsc_pkg for states, command and status types.
module tsc_ctrl import tsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [TCNT_W-1:0] term_count,
  output logic              out_valid,
  input  logic              out_ready,
  input  tsc_stat_t         stat,
  output tsc_cmd_t          cmd
);

  tsc_state_t       state;
  tsc_state_t       state_next;
  phase_t           phase;
  phase_t           phase_next;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] n_next;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] i_next;
  logic [CNT_W-1:0] i_inc;
  logic             out_set;
  logic             out_free;

  assign i_inc    = i + 1'b1;
  assign out_free = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      phase     <= PH_SQ;
      n         <= '0;
      i         <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      n     <= n_next;
      i     <= i_next;
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    n_next       = n;
    i_next       = i;
    out_set      = 1'b0;
    in_ready     = 1'b0;
    cmd.load_in  = 1'b0;
    cmd.mul_op   = MUL_NONE;
    cmd.acc_op   = ACC_NONE;
    cmd.sq       = (phase == PH_SQ);
    cmd.div_op   = DIV_NONE;
    cmd.load_d   = 1'b0;
    cmd.odd      = (phase == PH_SIN);
    cmd.term_idx = i;
    cmd.take     = TAKE_NONE;

    unique case (state)
      ST_IDLE: begin
        in_ready = ~rst;
        if (in_valid && !rst) begin
          cmd.load_in = 1'b1;
          phase_next  = PH_SQ;
          if (term_count == '0) begin
            n_next = CNT_W'(1);
          end else if (int'(term_count) > MAX_TERMS) begin
            n_next = CNT_W'(MAX_TERMS);
          end else begin
            n_next = CNT_W'(term_count);
          end
          state_next = ST_ANG_MUL;
        end
      end
      ST_ANG_MUL: begin
        cmd.mul_op = MUL_ANGLE;
        state_next = ST_ANG_START;
      end
      ST_ANG_START: begin
        cmd.div_op = DIV_ANGLE;
        state_next = ST_ANG_DIV;
      end
      ST_ANG_DIV: begin
        if (!stat.div_busy) begin
          cmd.take   = TAKE_X;
          state_next = ST_MQ_HH;
        end
      end
      ST_MQ_HH: begin
        cmd.mul_op = MUL_HH;
        cmd.load_d = 1'b1;
        state_next = ST_MQ_HL;
      end
      ST_MQ_HL: begin
        cmd.acc_op = ACC_HH;
        cmd.mul_op = MUL_HL;
        state_next = ST_MQ_LH;
      end
      ST_MQ_LH: begin
        cmd.acc_op = ACC_FULL;
        cmd.mul_op = MUL_LH;
        state_next = ST_MQ_LL;
      end
      ST_MQ_LL: begin
        cmd.acc_op = ACC_FULL;
        cmd.mul_op = MUL_LL;
        state_next = ST_MQ_FIN;
      end
      ST_MQ_FIN: begin
        cmd.acc_op = ACC_ROUND;
        state_next = (phase == PH_SQ) ? ST_X2 : ST_TERM_START;
      end
      ST_X2: begin
        cmd.take   = TAKE_X2;
        phase_next = PH_SIN;
        state_next = ST_SER_INIT;
      end
      ST_SER_INIT: begin
        cmd.take   = (phase == PH_SIN) ? TAKE_INIT_SIN : TAKE_INIT_COS;
        i_next     = CNT_W'(1);
        state_next = (CNT_W'(1) < n) ? ST_MQ_HH : ST_SER_END;
      end
      ST_TERM_START: begin
        cmd.div_op = DIV_TERM;
        state_next = ST_TERM_DIV;
      end
      ST_TERM_DIV: begin
        if (!stat.div_busy) begin
          cmd.take   = TAKE_TERM;
          i_next     = i_inc;
          state_next = (i_inc < n) ? ST_MQ_HH : ST_SER_END;
        end
      end
      ST_SER_END: begin
        if (phase == PH_SIN) begin
          cmd.take   = TAKE_SINE;
          phase_next = PH_COS;
          state_next = ST_SER_INIT;
        end else if (out_free) begin
          cmd.take   = TAKE_OUT;
          out_set    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
